[design/tower_energy_quality_accumulator_defines.svh]
// Assertion macros for the checker of the tower accumulator.
`ifndef TOWER_ENERGY_QUALITY_ACCUMULATOR_DEFINES_SVH
`define TOWER_ENERGY_QUALITY_ACCUMULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TQA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/tqa_pkg.sv]
`timescale 1ns / 1ps

package tqa_pkg;

   localparam int TOWERS     = 7168;
   localparam int REGIONS    = 4;
   localparam int ETA_TABLE  = 33;
   localparam int IDX_W      = $clog2(TOWERS);
   localparam int SIDE_STEP  = TOWERS / 4;
   localparam int LAYER_STEP = TOWERS / 2;

   // Divider operand widths for the mean quality.
   localparam int NUM_W = 74;
   localparam int DEN_W = 49;
   localparam int CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_CELL  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic [1:0]  KIND_FWD    = 2'd1;
   localparam logic [1:0]  KIND_TILE   = 2'd2;
   localparam logic [1:0]  FWD_REGION  = 2'd3;
   localparam logic [4:0]  NO_SECOND   = 5'd31;
   localparam logic [15:0] TILE_MASK   = 16'h8080;
   localparam logic [15:0] LAR_MASK    = 16'h2000;
   localparam logic [17:0] K_FWD       = 18'd134218;
   localparam logic signed [31:0] BAD_QUALITY = -32'sd256000000;

   typedef struct packed {
      logic signed [47:0] energy;
      logic signed [63:0] quality;
      logic signed [47:0] weight;
   } tower_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } loc_type;

   function automatic logic [5:0] eta_count_of(logic [1:0] region);
      case (region)
         2'd0:    eta_count_of = 6'd25;
         2'd1:    eta_count_of = 6'd3;
         2'd2:    eta_count_of = 6'd1;
         default: eta_count_of = 6'd4;
      endcase
   endfunction

   function automatic logic [6:0] phi_count_of(logic [1:0] region);
      case (region)
         2'd0:    phi_count_of = 7'd64;
         2'd1:    phi_count_of = 7'd32;
         2'd2:    phi_count_of = 7'd32;
         default: phi_count_of = 7'd16;
      endcase
   endfunction

   function automatic logic [2:0] eta_shift_of(logic [1:0] region);
      case (region)
         2'd0:    eta_shift_of = 3'd6;
         2'd1:    eta_shift_of = 3'd5;
         2'd2:    eta_shift_of = 3'd5;
         default: eta_shift_of = 3'd4;
      endcase
   endfunction

   function automatic logic [10:0] base_index_of(logic [1:0] region);
      case (region)
         2'd0:    base_index_of = 11'd0;
         2'd1:    base_index_of = 11'd1600;
         2'd2:    base_index_of = 11'd1696;
         default: base_index_of = 11'd1728;
      endcase
   endfunction

   function automatic logic [4:0] base_bin_of(logic [1:0] region);
      case (region)
         2'd0:    base_bin_of = 5'd0;
         2'd1:    base_bin_of = 5'd25;
         2'd2:    base_bin_of = 5'd28;
         default: base_bin_of = 5'd29;
      endcase
   endfunction

   // Transverse scale per eta bin: round(65536 * 2.048 / cosh(eta centre)).
   function automatic logic [17:0] et_scale_of(logic [5:0] bin);
      case (bin)
         6'd0:  et_scale_of = 18'd134050;
         6'd1:  et_scale_of = 18'd132721;
         6'd2:  et_scale_of = 18'd130130;
         6'd3:  et_scale_of = 18'd126397;
         6'd4:  et_scale_of = 18'd121688;
         6'd5:  et_scale_of = 18'd116196;
         6'd6:  et_scale_of = 18'd110123;
         6'd7:  et_scale_of = 18'd103668;
         6'd8:  et_scale_of = 18'd97011;
         6'd9:  et_scale_of = 18'd90308;
         6'd10: et_scale_of = 18'd83688;
         6'd11: et_scale_of = 18'd77251;
         6'd12: et_scale_of = 18'd71074;
         6'd13: et_scale_of = 18'd65207;
         6'd14: et_scale_of = 18'd59683;
         6'd15: et_scale_of = 18'd54519;
         6'd16: et_scale_of = 18'd49719;
         6'd17: et_scale_of = 18'd45280;
         6'd18: et_scale_of = 18'd41191;
         6'd19: et_scale_of = 18'd37434;
         6'd20: et_scale_of = 18'd33994;
         6'd21: et_scale_of = 18'd30850;
         6'd22: et_scale_of = 18'd27982;
         6'd23: et_scale_of = 18'd25370;
         6'd24: et_scale_of = 18'd22993;
         6'd25: et_scale_of = 18'd19828;
         6'd26: et_scale_of = 18'd16263;
         6'd27: et_scale_of = 18'd13332;
         6'd28: et_scale_of = 18'd11482;
         6'd29: et_scale_of = 18'd8838;
         6'd30: et_scale_of = 18'd5781;
         6'd31: et_scale_of = 18'd3781;
         6'd32: et_scale_of = 18'd2472;
         default: et_scale_of = 18'd0;
      endcase
   endfunction

   function automatic loc_type locate(logic side, logic layer, logic [1:0] region,
                                      logic [4:0] eta, logic [5:0] phi);
      logic [IDX_W:0] sum;
      loc_type        res;
      sum = (IDX_W+1)'(base_index_of(region))
          + ((IDX_W+1)'(eta) << eta_shift_of(region))
          + (IDX_W+1)'(phi)
          + (side  ? (IDX_W+1)'(SIDE_STEP)  : '0)
          + (layer ? (IDX_W+1)'(LAYER_STEP) : '0);
      res.found = (int'(region) < REGIONS)
               && ({1'b0, eta} < eta_count_of(region))
               && ({1'b0, phi} < phi_count_of(region))
               && (sum < (IDX_W+1)'(TOWERS));
      res.idx = sum[IDX_W-1:0];
      return res;
   endfunction

   function automatic logic [17:0] k_of(logic [1:0] region, logic [4:0] eta);
      logic [5:0] bin;
      bin = 6'(base_bin_of(region)) + 6'(eta);
      if (region == FWD_REGION) return K_FWD;
      if (int'(bin) < ETA_TABLE) return et_scale_of(bin);
      return 18'd0;
   endfunction

endpackage

[design/tqa_if.sv]
`timescale 1ns / 1ps

interface tqa_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic               side;
   logic               layer;
   logic [1:0]         region_code;
   logic [4:0]         eta_bin;
   logic [5:0]         phi_bin;
   logic [4:0]         second_eta_bin;
   logic [1:0]         cell_kind;
   logic signed [39:0] cell_energy;
   logic [15:0]        provenance_bits;
   logic [15:0]        cell_quality;
   logic [15:0]        sin_theta;

   modport source (output valid, opcode, side, layer, region_code, eta_bin, phi_bin,
                   second_eta_bin, cell_kind, cell_energy, provenance_bits,
                   cell_quality, sin_theta, input ready);
   modport sink (input valid, opcode, side, layer, region_code, eta_bin, phi_bin,
                 second_eta_bin, cell_kind, cell_energy, provenance_bits,
                 cell_quality, sin_theta, output ready);
endinterface

interface tqa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] tower_et;
   logic signed [31:0] mean_quality;
   logic               quality_valid;

   modport source (output valid, tower_et, mean_quality, quality_valid, input ready);
   modport sink (input valid, tower_et, mean_quality, quality_valid, output ready);
endinterface

[design/tqa_ram.sv]
`timescale 1ns / 1ps

module tqa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/tqa_div.sv]
`timescale 1ns / 1ps

module tqa_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tqa_pkg::NUM_W-1:0] numer,
   input  logic [tqa_pkg::DEN_W-1:0] denom,
   output logic                      done,
   output logic [tqa_pkg::NUM_W-1:0] quot
);
   import tqa_pkg::*;

   // Restoring division, one quotient bit per cycle, MSB first. The
   // numerator register fills with quotient bits as it shifts out.
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W+1:0] diff;

   always_comb begin
      rem_shift = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, den_ff};
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

[design/tower_energy_quality_accumulator.sv]
`timescale 1ns / 1ps
// Cell beat: one tower memory read-modify-write per tower (read issued in the accept cycle),
// with ready low through the write state, S_CELL1, and for a split cell also S_CELL2.
// Query beat: read, scale (S_QMUL, S_QET), the 74-step divider and output, with ready low
// throughout; a zero weight skips the divider and a missing tower goes straight to output.
// Clear beat and reset: a clearing pass writes zero to all 7168 towers, one per cycle,
// with ready low for the whole pass. A waiting result holds a finished query in its last state.
module tower_energy_quality_accumulator (
   input  logic     clock,
   input  logic     reset,
   tqa_req_if.sink  req_bus,
   tqa_rsp_if.source rsp_bus
);
   import tqa_pkg::*;

   // The sequencer owns the tower memory. Cells read their tower in the
   // accept cycle and write the updated sums on the next cycle; the second
   // tower of a split cell is read while the first is written. When both
   // halves of a split name the same tower, the sums written by the first
   // half are forwarded to the second update instead of the stale read.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CELL1,
      S_CELL2,
      S_QMUL,
      S_QET,
      S_QDIV,
      S_QOUT
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]   idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic               found_ff, found_in, split_ff, split_in;
   logic               same_ff, same_in;
   tower_type          fwd_ff, fwd_in;
   logic               counted_ff, counted_in;
   logic signed [39:0] e_ff, e_in;
   logic [1:0]         kind_ff, kind_in;
   logic [15:0]        qual_ff, qual_in, sinth_ff, sinth_in;
   logic [17:0]        k_ff, k_in;
   logic [41:0]        prod_hi_ff, prod_hi_in, prod_lo_ff, prod_lo_in;
   logic               neg_et_ff, neg_et_in, neg_q_ff, neg_q_in;
   logic               wzero_ff, wzero_in;
   logic [NUM_W-1:0]   numer_ff, numer_in;
   logic [DEN_W-1:0]   denom_ff, denom_in;
   logic signed [47:0] et_res_ff, et_res_in;
   logic signed [31:0] mq_res_ff, mq_res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_et_ff, rsp_et_in;
   logic signed [31:0] rsp_mq_ff, rsp_mq_in;
   logic               rsp_qv_ff, rsp_qv_in;

   logic               ram_we, ram_re;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   tower_type          ram_wdata, ram_rdata;

   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_quot;

   logic               accept;
   loc_type            loc1, loc2;
   logic               cell_split;

   // Cell contribution terms, computed from the registered cell beat.
   logic signed [41:0] w_term, en_term;
   logic signed [56:0] fwd_prod, fwd_round, fwd_shift;
   logic signed [58:0] wq_term;
   tower_type          base;
   tower_type          upd;

   logic [47:0]        e_mag, w_mag;
   logic [63:0]        q_mag;
   logic [50:0]        et_raw;
   logic               q_ovf;

   function automatic logic signed [47:0] sat48(logic signed [47:0] a,
                                               logic signed [41:0] b);
      logic signed [49:0] s;
      s = {{2{a[47]}}, a} + {{8{b[41]}}, b};
      if (s[49:47] == 3'b000 || s[49:47] == 3'b111) return s[47:0];
      return s[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
   endfunction

   function automatic logic signed [63:0] sat64(logic signed [63:0] a,
                                               logic signed [58:0] b);
      logic signed [65:0] s;
      s = {{2{a[63]}}, a} + {{7{b[58]}}, b};
      if (s[65:63] == 3'b000 || s[65:63] == 3'b111) return s[63:0];
      return s[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
   endfunction

   tqa_ram #(
      .WIDTH($bits(tower_type)),
      .DEPTH(TOWERS)
   ) u_tqa_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   tqa_div u_tqa_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(numer_ff),
      .denom(denom_ff),
      .done (div_done),
      .quot (div_quot)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tower_et      = rsp_et_ff;
   assign rsp_bus.mean_quality  = rsp_mq_ff;
   assign rsp_bus.quality_valid = rsp_qv_ff;

   always_comb begin
      loc1 = locate(req_bus.side, req_bus.layer, req_bus.region_code,
                    req_bus.eta_bin, req_bus.phi_bin);
      loc2 = locate(req_bus.side, req_bus.layer, req_bus.region_code,
                    req_bus.second_eta_bin, req_bus.phi_bin);
      cell_split = (req_bus.second_eta_bin != NO_SECOND) && loc2.found;
   end

   // A split cell gives E to each tower; a whole cell gives 2E, or for a
   // forward cell E*sin(theta) rounded half up. The weight never carries
   // the sin theta factor.
   always_comb begin
      base      = (state_ff == S_CELL2 && same_ff) ? fwd_ff : ram_rdata;
      w_term    = split_ff ? {{2{e_ff[39]}}, e_ff} : {e_ff[39], e_ff, 1'b0};
      fwd_prod  = e_ff * $signed({1'b0, sinth_ff});
      fwd_round = fwd_prod + 57'sd16384;
      fwd_shift = fwd_round >>> 15;
      if (!split_ff && kind_ff == KIND_FWD) begin
         en_term = fwd_shift[41:0];
      end else begin
         en_term = w_term;
      end
      wq_term = w_term * $signed({1'b0, qual_ff});
      upd.energy  = sat48(base.energy, en_term);
      upd.quality = counted_ff ? sat64(base.quality, wq_term) : base.quality;
      upd.weight  = counted_ff ? sat48(base.weight, w_term) : base.weight;
   end

   always_comb begin
      e_mag = ram_rdata.energy[47] ? (48'd0 - ram_rdata.energy) : ram_rdata.energy;
      q_mag = ram_rdata.quality[63] ? (64'd0 - ram_rdata.quality) : ram_rdata.quality;
      w_mag = ram_rdata.weight[47] ? (48'd0 - ram_rdata.weight) : ram_rdata.weight;
      et_raw = {1'b0, prod_hi_ff, 8'd0} + 51'((43'(prod_lo_ff) + 43'd32768) >> 16);
      q_ovf  = |div_quot[NUM_W-1:31];
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      idx1_in      = idx1_ff;
      idx2_in      = idx2_ff;
      found_in     = found_ff;
      split_in     = split_ff;
      same_in      = same_ff;
      fwd_in       = fwd_ff;
      counted_in   = counted_ff;
      e_in         = e_ff;
      kind_in      = kind_ff;
      qual_in      = qual_ff;
      sinth_in     = sinth_ff;
      k_in         = k_ff;
      prod_hi_in   = prod_hi_ff;
      prod_lo_in   = prod_lo_ff;
      neg_et_in    = neg_et_ff;
      neg_q_in     = neg_q_ff;
      wzero_in     = wzero_ff;
      numer_in     = numer_ff;
      denom_in     = denom_ff;
      et_res_in    = et_res_ff;
      mq_res_in    = mq_res_ff;
      rsp_et_in    = rsp_et_ff;
      rsp_mq_in    = rsp_mq_ff;
      rsp_qv_in    = rsp_qv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ram_we       = 1'b0;
      ram_waddr    = idx1_ff;
      ram_wdata    = upd;
      ram_re       = 1'b0;
      ram_raddr    = loc1.idx;
      div_start    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
            if (clr_addr_ff == IDX_W'(TOWERS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               idx1_in  = loc1.idx;
               idx2_in  = loc2.idx;
               found_in = loc1.found;
               split_in = cell_split;
               same_in  = (loc1.idx == loc2.idx);
               e_in     = req_bus.cell_energy;
               kind_in  = req_bus.cell_kind;
               qual_in  = req_bus.cell_quality;
               sinth_in = req_bus.sin_theta;
               k_in     = k_of(req_bus.region_code, req_bus.eta_bin);
               // Tile cells use the tile mask; a split liquid argon cell
               // never counts toward quality.
               if (cell_split) begin
                  counted_in = (req_bus.cell_kind == KIND_TILE)
                            && ((req_bus.provenance_bits & TILE_MASK) != '0);
               end else begin
                  counted_in = (req_bus.provenance_bits &
                               ((req_bus.cell_kind == KIND_TILE) ? TILE_MASK : LAR_MASK))
                               != '0;
               end
               case (opcode_type'(req_bus.opcode))
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end
                  OP_CELL: begin
                     ram_re   = loc1.found;
                     state_in = S_CELL1;
                  end
                  OP_QUERY: begin
                     if (loc1.found) begin
                        ram_re   = 1'b1;
                        state_in = S_QMUL;
                     end else begin
                        // Missing tower: zero energy and the invalid quality.
                        et_res_in = '0;
                        mq_res_in = BAD_QUALITY;
                        wzero_in  = 1'b1;
                        state_in  = S_QOUT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CELL1: begin
            ram_we    = found_ff;
            ram_waddr = idx1_ff;
            fwd_in    = upd;
            if (found_ff && split_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx2_ff;
               state_in  = S_CELL2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CELL2: begin
            ram_we    = 1'b1;
            ram_waddr = idx2_ff;
            state_in  = S_IDLE;
         end
         S_QMUL: begin
            // Energy magnitude is scaled in two 24-bit halves.
            prod_hi_in = 42'(e_mag[47:24]) * 42'(k_ff);
            prod_lo_in = 42'(e_mag[23:0]) * 42'(k_ff);
            neg_et_in  = ram_rdata.energy[47];
            neg_q_in   = ram_rdata.quality[63] ^ ram_rdata.weight[47];
            wzero_in   = (ram_rdata.weight == '0);
            // Mean = floor((512*|q| + |w|) / (2*|w|)), rounding half up.
            numer_in   = {1'b0, q_mag, 9'd0} + NUM_W'(w_mag);
            denom_in   = {w_mag, 1'b0};
            state_in   = S_QET;
         end
         S_QET: begin
            if (et_raw[50:47] != 4'd0) begin
               et_res_in = neg_et_ff ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
               et_res_in = neg_et_ff ? (48'sd0 - $signed(et_raw[47:0]))
                                     : $signed(et_raw[47:0]);
            end
            if (wzero_ff) begin
               mq_res_in = BAD_QUALITY;
               state_in  = S_QOUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_QDIV;
            end
         end
         S_QDIV: begin
            if (div_done) begin
               if (q_ovf) begin
                  mq_res_in = neg_q_ff ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
               end else begin
                  mq_res_in = neg_q_ff ? (32'sd0 - $signed(div_quot[31:0]))
                                       : $signed(div_quot[31:0]);
               end
               state_in = S_QOUT;
            end
         end
         S_QOUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_et_in    = et_res_ff;
               rsp_mq_in    = mq_res_ff;
               rsp_qv_in    = !wzero_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx1_ff    <= idx1_in;
      idx2_ff    <= idx2_in;
      found_ff   <= found_in;
      split_ff   <= split_in;
      same_ff    <= same_in;
      fwd_ff     <= fwd_in;
      counted_ff <= counted_in;
      e_ff       <= e_in;
      kind_ff    <= kind_in;
      qual_ff    <= qual_in;
      sinth_ff   <= sinth_in;
      k_ff       <= k_in;
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      neg_et_ff  <= neg_et_in;
      neg_q_ff   <= neg_q_in;
      wzero_ff   <= wzero_in;
      numer_ff   <= numer_in;
      denom_ff   <= denom_in;
      et_res_ff  <= et_res_in;
      mq_res_ff  <= mq_res_in;
      rsp_et_ff  <= rsp_et_in;
      rsp_mq_ff  <= rsp_mq_in;
      rsp_qv_ff  <= rsp_qv_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/tqa_checker.sv]
`timescale 1ns / 1ps
`include "tower_energy_quality_accumulator_defines.svh"

module tqa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_tower_et,
   input logic signed [31:0] rsp_mean_quality,
   input logic               rsp_quality_valid
);
   import tqa_pkg::*;

   // A stalled result beat stays valid and keeps its energy and mean quality.
   `TQA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tower_et) && $stable(rsp_mean_quality), "result beat changed while stalled")

   // Clears and cells occupy the tower memory, so an accepted clear or cell beat takes ready low.
   `TQA_ASSERT_NEXT(a_busy_after_write, req_valid && req_ready && (req_opcode == OP_CLEAR || req_opcode == OP_CELL), !req_ready, "ready high right after a clear or cell beat")

   // An invalid quality always carries the marker value.
   `TQA_ASSERT_SAME(a_bad_quality, rsp_valid && !rsp_quality_valid, rsp_mean_quality == BAD_QUALITY, "invalid quality without marker value")

endmodule

bind tower_energy_quality_accumulator tqa_checker u_tqa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_opcode       (req_bus.opcode),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_tower_et     (rsp_bus.tower_et),
   .rsp_mean_quality (rsp_bus.mean_quality),
   .rsp_quality_valid(rsp_bus.quality_valid)
);
